### rtl/core/crast_pkg.sv
// Shared constants, register codes, state and job types of the circle rasterizer.
package crast_pkg;

	// field widths
	localparam int RAD_W  = 10;
	localparam int CTR_W  = 11;
	localparam int PT_W   = 12;
	localparam int CFG_W  = (RAD_W > CTR_W) ? RAD_W : CTR_W;
	localparam int CFG_IDX_W = 2;

	// shared multiplier: operand holds column+1
	localparam int MUL_W  = RAD_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	// square root: radicand, remainder, two radicand bits per step
	localparam int SQ_W     = 2 * RAD_W;
	localparam int REM_W    = RAD_W + 1;
	localparam int SQ_STEPS = RAD_W;
	localparam int SQ_CNT_W = (SQ_STEPS > 1) ? $clog2(SQ_STEPS) : 1;

	// point index width: eight points emitted per column
	localparam int PTS_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_RADIUS   = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_JJ,
		ST_CHECK,
		ST_SQRT,
		ST_EMIT
	} seq_state_t;

	// one column handed to the emitter
	typedef struct packed {
		logic [RAD_W-1:0] col;
		logic [RAD_W-1:0] y;
		logic             circle_done;
	} emit_job_t;

endpackage

### rtl/core/crast_req_if.sv
// Request channel: one word per tick, carrying the restart flag.
interface crast_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

### rtl/core/crast_pix_if.sv
// Pixel channel: one plotted point per word.
interface crast_pix_if;
	logic                             valid;
	logic                             ready;
	logic signed [crast_pkg::PT_W-1:0] point_x;
	logic signed [crast_pkg::PT_W-1:0] point_y;
	logic                             last_of_column;
	logic                             circle_done;

	modport source (output valid, output point_x, output point_y,
		output last_of_column, output circle_done, input ready);
	modport sink   (input valid, input point_x, input point_y,
		input last_of_column, input circle_done, output ready);
endinterface

### rtl/core/crast_isqrt.sv
// Digit-serial integer square root with remainder, two radicand bits per cycle.
module crast_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [crast_pkg::SQ_W-1:0]   n,
	output logic                         done,
	output logic [crast_pkg::RAD_W-1:0]  root,
	output logic [crast_pkg::REM_W-1:0]  rem
);

	logic                           busy_q;
	logic                           done_q;
	logic [crast_pkg::SQ_CNT_W-1:0] cnt_q;
	logic [crast_pkg::SQ_W-1:0]     n_q;
	logic [crast_pkg::REM_W-1:0]    rem_q;
	logic [crast_pkg::RAD_W-1:0]    root_q;

	logic [crast_pkg::REM_W+1:0]    shifted;
	logic [crast_pkg::REM_W+1:0]    trial;
	logic                           fits;

	// bring down the next two radicand bits and try root*4+1
	assign shifted = {rem_q, n_q[crast_pkg::SQ_W-1 -: 2]};
	assign trial   = (crast_pkg::REM_W + 2)'({root_q, 2'b01});
	assign fits    = (shifted >= trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == crast_pkg::SQ_CNT_W'(crast_pkg::SQ_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= n_q << 2;
			if (fits) begin
				rem_q  <= crast_pkg::REM_W'(shifted - trial);
				root_q <= {root_q[crast_pkg::RAD_W-2:0], 1'b1};
			end else begin
				rem_q  <= crast_pkg::REM_W'(shifted);
				root_q <= {root_q[crast_pkg::RAD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
	assign rem  = rem_q;

endmodule

### rtl/core/crast_emit.sv
// Eight-way symmetry emitter: one point per cycle while the sink is ready, into a registered output word.
module crast_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  crast_pkg::emit_job_t              job,
	input  logic signed [crast_pkg::CTR_W-1:0] center_x,
	input  logic signed [crast_pkg::CTR_W-1:0] center_y,
	output logic                              busy,
	crast_pix_if.source                       pix
);

	logic                          busy_q;
	logic [crast_pkg::PTS_W-1:0]   k_q;
	logic                          vld_q;
	logic [crast_pkg::PT_W-1:0]    px_q;
	logic [crast_pkg::PT_W-1:0]    py_q;
	logic                          last_q;
	logic                          done_q;

	logic                          load;
	logic [crast_pkg::RAD_W-1:0]   mag_x;
	logic [crast_pkg::RAD_W-1:0]   mag_y;
	logic                          neg_x;
	logic                          neg_y;
	logic [crast_pkg::PT_W-1:0]    off_x;
	logic [crast_pkg::PT_W-1:0]    off_y;

	// output word free or leaving this cycle
	assign load = busy_q && (!vld_q || pix.ready);

	// point order: (i,y) (i,-y) (-i,-y) (-i,y) (y,i) (y,-i) (-y,-i) (-y,i)
	always_comb begin
		mag_x = k_q[2] ? job.y : job.col;
		mag_y = k_q[2] ? job.col : job.y;
		neg_x = k_q[1];
		neg_y = k_q[1] ^ k_q[0];
		off_x = neg_x ? -crast_pkg::PT_W'(mag_x) : crast_pkg::PT_W'(mag_x);
		off_y = neg_y ? -crast_pkg::PT_W'(mag_y) : crast_pkg::PT_W'(mag_y);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (load) begin
				k_q <= k_q + 1'b1;
				if (k_q == '1)
					busy_q <= 1'b0;
			end
			if (load)
				vld_q <= 1'b1;
			else if (pix.ready)
				vld_q <= 1'b0;
		end
	end

	// output word, coordinates wrap to the point width
	always_ff @(posedge clk) begin
		if (load) begin
			px_q   <= crast_pkg::PT_W'(center_x) + off_x;
			py_q   <= crast_pkg::PT_W'(center_y) + off_y;
			last_q <= (k_q == '1);
			done_q <= job.circle_done;
		end
	end

	assign busy               = busy_q;
	assign pix.valid          = vld_q;
	assign pix.point_x        = px_q;
	assign pix.point_y        = py_q;
	assign pix.last_of_column = last_q;
	assign pix.circle_done    = done_q;

endmodule

### rtl/core/circle_octant_sqrt_rasterizer_top.sv
// Circle rasterizer top: config registers, column sequencer, shared multiplier.
// Sequence for a tick word taken for a column with i > 0: three multiplies, a check,
// the 10-step square root, then the emitter; column 0 skips the square root.
// One tick word per column; the next is taken only once the emitter has loaded
// all 8 points, which stall while the sink is not ready. A column that no longer
// fits ends after the check; a tick word after the final column is taken and skipped.
// Reset: center, radius, column index and finished flag clear at once.
module circle_octant_sqrt_rasterizer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [crast_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [crast_pkg::CFG_W-1:0]      cfg_data,
	crast_req_if.sink                        req,
	crast_pix_if.source                      pix
);

	crast_pkg::seq_state_t state_q, state_nx;

	// config registers
	logic signed [crast_pkg::CTR_W-1:0] center_x_q;
	logic signed [crast_pkg::CTR_W-1:0] center_y_q;
	logic [crast_pkg::RAD_W-1:0]        radius_q;

	// column state
	logic [crast_pkg::RAD_W-1:0]        col_q;
	logic                               fin_q;

	// per-column work registers
	logic [crast_pkg::RAD_W-1:0]        i_q;
	logic [crast_pkg::PROD_W-1:0]       rr_q;
	logic [crast_pkg::PROD_W-1:0]       ii_q;
	logic [crast_pkg::PROD_W-1:0]       jj_q;
	logic [crast_pkg::RAD_W-1:0]        y_q;
	logic                               last_col_q;

	logic                               accept;
	logic                               skip;
	logic                               col_ok;
	logic                               next_ok;
	logic                               last_col;
	logic [crast_pkg::MUL_W-1:0]        mul_a;
	logic [crast_pkg::PROD_W-1:0]       product;
	logic                               sq_start;
	logic                               emit_start;
	logic                               mark_fin;
	logic                               sq_done;
	logic [crast_pkg::RAD_W-1:0]        sq_root;
	logic [crast_pkg::REM_W-1:0]        sq_rem;
	logic [crast_pkg::RAD_W-1:0]        y_round;
	logic                               emit_busy;
	crast_pkg::emit_job_t               job;

	assign accept = req.valid && req.ready;
	assign skip   = fin_q && !req.restart;

	// column tests: 2*i*i <= r*r now, and for column i+1
	assign col_ok  = (i_q == '0) ||
		(((crast_pkg::PROD_W + 1)'(ii_q) << 1) <= (crast_pkg::PROD_W + 1)'(rr_q));
	assign next_ok =
		(((crast_pkg::PROD_W + 1)'(jj_q) << 1) <= (crast_pkg::PROD_W + 1)'(rr_q));

	// final-column flag: live in the check cycle, registered afterwards
	assign last_col = (state_q == crast_pkg::ST_CHECK) ? !next_ok : last_col_q;

	// round to nearest: up when remainder exceeds root
	assign y_round = sq_root + crast_pkg::RAD_W'(sq_rem > crast_pkg::REM_W'(sq_root));

	// shared multiplier, squares one operand per cycle
	assign product = crast_pkg::PROD_W'(mul_a) * crast_pkg::PROD_W'(mul_a);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= crast_pkg::ST_IDLE;
		else
			state_q <= state_nx;
	end

	// next state and sequencer controls
	always_comb begin
		state_nx   = state_q;
		req.ready  = 1'b0;
		mul_a      = '0;
		sq_start   = 1'b0;
		emit_start = 1'b0;
		mark_fin   = 1'b0;
		unique case (state_q)
			crast_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && !skip)
					state_nx = crast_pkg::ST_MUL_RR;
			end
			crast_pkg::ST_MUL_RR: begin
				mul_a    = crast_pkg::MUL_W'(radius_q);
				state_nx = crast_pkg::ST_MUL_II;
			end
			crast_pkg::ST_MUL_II: begin
				mul_a    = crast_pkg::MUL_W'(i_q);
				state_nx = crast_pkg::ST_MUL_JJ;
			end
			crast_pkg::ST_MUL_JJ: begin
				mul_a    = crast_pkg::MUL_W'(i_q) + 1'b1;
				state_nx = crast_pkg::ST_CHECK;
			end
			crast_pkg::ST_CHECK: begin
				if (!col_ok) begin
					mark_fin = 1'b1;
					state_nx = crast_pkg::ST_IDLE;
				end else if (i_q == '0) begin
					emit_start = 1'b1;
					state_nx   = crast_pkg::ST_EMIT;
				end else begin
					sq_start = 1'b1;
					state_nx = crast_pkg::ST_SQRT;
				end
			end
			crast_pkg::ST_SQRT: begin
				if (sq_done) begin
					emit_start = 1'b1;
					state_nx   = crast_pkg::ST_EMIT;
				end
			end
			crast_pkg::ST_EMIT: begin
				if (!emit_busy)
					state_nx = crast_pkg::ST_IDLE;
			end
			default: state_nx = crast_pkg::ST_IDLE;
		endcase
	end

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
		end else if (cfg_we) begin
			unique case (crast_pkg::cfg_reg_t'(cfg_idx))
				crast_pkg::REG_CENTER_X: center_x_q <= crast_pkg::CTR_W'(cfg_data);
				crast_pkg::REG_CENTER_Y: center_y_q <= crast_pkg::CTR_W'(cfg_data);
				crast_pkg::REG_RADIUS:   radius_q   <= crast_pkg::RAD_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// column index and finished flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			fin_q <= 1'b0;
		end else begin
			if (accept && req.restart) begin
				col_q <= '0;
				fin_q <= 1'b0;
			end
			if (mark_fin)
				fin_q <= 1'b1;
			if (emit_start) begin
				if (last_col)
					fin_q <= 1'b1;
				else
					col_q <= i_q + 1'b1;
			end
		end
	end

	// per-column datapath
	always_ff @(posedge clk) begin
		if (accept)
			i_q <= req.restart ? '0 : col_q;
		if (state_q == crast_pkg::ST_MUL_RR)
			rr_q <= product;
		if (state_q == crast_pkg::ST_MUL_II)
			ii_q <= product;
		if (state_q == crast_pkg::ST_MUL_JJ)
			jj_q <= product;
		if (state_q == crast_pkg::ST_CHECK) begin
			last_col_q <= !next_ok;
			y_q        <= radius_q;
		end
		if (state_q == crast_pkg::ST_SQRT && sq_done)
			y_q <= y_round;
	end

	crast_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n      (crast_pkg::SQ_W'(rr_q - ii_q)),
		.done   (sq_done),
		.root   (sq_root),
		.rem    (sq_rem)
	);

	assign job.col         = i_q;
	assign job.y           = y_q;
	assign job.circle_done = last_col_q;

	crast_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (emit_start),
		.job      (job),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.busy     (emit_busy),
		.pix      (pix)
	);

endmodule
